FILE: rtl/filmic_tone_curve_rgb_core_defines.svh
// ----------------------------------------------------------------------------
// filmic_tone_curve_rgb_core_defines
// Assertion macros for the filmic tone curve core.
// ----------------------------------------------------------------------------
`ifndef FILMIC_TONE_CURVE_RGB_CORE_DEFINES_SVH
`define FILMIC_TONE_CURVE_RGB_CORE_DEFINES_SVH

// condition in one cycle implies consequence in the next
`define FTC_ASSERT_NEXT(label, clk, cond, cons, msg) \
  label: assert property (@(posedge clk) (cond) |=> (cons)) else $error(msg);

// condition implies consequence in the same cycle, outside reset
`define FTC_ASSERT_SAME(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// Constants for the filmic tone curve: fixed point coefficients and timing.
// ----------------------------------------------------------------------------
`default_nettype none
package ftc_pkg;
  localparam int IN_W          = 24;
  localparam int OUT_FRAC_BITS = 14;
  localparam int QUOT_BITS     = 28;
  // lane registers: five front stages, divider steps, curve and product
  localparam int LANE_LAT      = 5 + QUOT_BITS + 2;

  localparam logic [13:0] COEF_A   = 14'd9830;
  localparam logic [15:0] COEF_B   = 16'd32768;
  localparam logic [11:0] COEF_CB  = 12'd3277;
  localparam logic [8:0]  COEF_DE  = 9'd262;
  localparam logic [11:0] COEF_DF  = 12'd3932;
  localparam logic [24:0] E_OVER_F = 25'd17895697;
  localparam logic [16:0] WHITE    = 17'd90378;
endpackage
`default_nettype wire

FILE: rtl/ftc_if.sv
// ----------------------------------------------------------------------------
// ftc_in_if / ftc_out_if
// Valid/ready channels for input pixels and tone-mapped pixels.
// ----------------------------------------------------------------------------
`default_nettype none
interface ftc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ftc_pkg::IN_W-1:0]   red_in;
  logic [ftc_pkg::IN_W-1:0]   green_in;
  logic [ftc_pkg::IN_W-1:0]   blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface ftc_out_if #(parameter int OUT_W = ftc_pkg::OUT_FRAC_BITS + 1);
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/ftc_div_step.sv
// ----------------------------------------------------------------------------
// ftc_div_step
// One restoring division step: one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ftc_div_step (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [31:0]                    rem_i,
  input  wire logic [31:0]                    den_i,
  input  wire logic [ftc_pkg::QUOT_BITS-1:0]  quo_i,
  output logic      [31:0]                    rem_o,
  output logic      [31:0]                    den_o,
  output logic      [ftc_pkg::QUOT_BITS-1:0]  quo_o
);
  logic [32:0] r2;
  logic        ge;
  logic [31:0] rem_nxt;

  always_comb begin
    r2      = {rem_i, 1'b0};
    ge      = r2 >= {1'b0, den_i};
    // remainder stays below the divisor
    rem_nxt = ge ? 32'(r2 - {1'b0, den_i}) : r2[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      den_o <= den_i;
      quo_o <= {quo_i[ftc_pkg::QUOT_BITS-2:0], ge};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ftc_lane.sv
// ----------------------------------------------------------------------------
// ftc_lane
// One colour channel through the filmic curve, white scale and rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module ftc_lane #(
  parameter int OUT_FRAC_BITS = ftc_pkg::OUT_FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ftc_pkg::IN_W-1:0]   chan_in,
  output logic      [OUT_FRAC_BITS:0]     chan_out
);
  localparam int QB = ftc_pkg::QUOT_BITS;
  localparam int SH = 44 - OUT_FRAC_BITS;
  localparam int RW = 46 - SH;

  logic [24:0] x1_r, x2_r;
  logic [38:0] ax_r;
  logic [31:0] tq_r, uq_r;
  logic [57:0] num_r, den_r, num4_r, den4_r;
  logic [4:0]  s_r, s_nxt;
  logic [39:0] t_c, u_c;
  logic [31:0] rem0_r, dv0_r;

  logic [31:0]    rem_a [QB+1];
  logic [31:0]    dv_a  [QB+1];
  logic [QB-1:0]  quo_a [QB+1];

  logic [QB-1:0] curve_r, curve_nxt;
  logic [44:0]   prod_r;
  logic [45:0]   rnd;
  logic [RW-1:0] res;

  always_comb begin
    t_c = 40'(ax_r) + (40'(ftc_pkg::COEF_CB) << 16);
    u_c = 40'(ax_r) + (40'(ftc_pkg::COEF_B) << 16);
    // smallest shift that brings the denominator below 2^32
    s_nxt = '0;
    for (int i = 32; i < 58; i++) begin
      if (den_r[i]) s_nxt = 5'(i - 31);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= {chan_in, 1'b0};
      ax_r   <= 39'(ftc_pkg::COEF_A) * 39'({chan_in, 1'b0});
      x2_r   <= x1_r;
      tq_r   <= t_c[39:8];
      uq_r   <= u_c[39:8];
      num_r  <= 58'(tq_r) * 58'(x2_r) + (58'(ftc_pkg::COEF_DE) << 24);
      den_r  <= 58'(uq_r) * 58'(x2_r) + (58'(ftc_pkg::COEF_DF) << 24);
      num4_r <= num_r;
      den4_r <= den_r;
      s_r    <= s_nxt;
      // numerator never exceeds the denominator
      rem0_r <= 32'(num4_r >> s_r);
      dv0_r  <= 32'(den4_r >> s_r);
    end
  end

  assign rem_a[0] = rem0_r;
  assign dv_a[0]  = dv0_r;
  assign quo_a[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_div
    ftc_div_step u_step (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_a[k]),
      .den_i (dv_a[k]),
      .quo_i (quo_a[k]),
      .rem_o (rem_a[k+1]),
      .den_o (dv_a[k+1]),
      .quo_o (quo_a[k+1])
    );
  end

  always_comb begin
    curve_nxt = (quo_a[QB] > QB'(ftc_pkg::E_OVER_F)) ?
                quo_a[QB] - QB'(ftc_pkg::E_OVER_F) : '0;
    rnd = 46'(prod_r) + (46'(1) << (SH - 1));
    res = RW'(rnd >> SH);
    chan_out = (res > RW'({(OUT_FRAC_BITS+1){1'b1}})) ?
               {(OUT_FRAC_BITS+1){1'b1}} : res[OUT_FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      curve_r <= curve_nxt;
      prod_r  <= 45'(curve_r) * 45'(ftc_pkg::WHITE);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/filmic_tone_curve_rgb_core.sv
// ----------------------------------------------------------------------------
// Filmic tone curve, one RGB pixel per word.
// in_ch carries three linear UQ8.16 channels; out_ch returns three tone-mapped
// channels with OUT_FRAC_BITS fraction bits, saturated at the top of range.
// A word is accepted when valid and ready are both high on a rising clk edge.
// Three identical lanes run side by side; the output register merges them
// into one result word with a shared valid.
// Throughput: one word per cycle, sustained while the receiver keeps ready high.
// From acceptance to out_ch.valid a word passes the LANE_LAT lane registers
// (28-step pipelined divider and multiply stages), then the output register.
// The pipeline advances whenever the output register is empty or being taken;
// when the receiver stalls, the whole pipeline holds and in_ch.ready drops.
// Reset (rst_n low, synchronous) clears all valid bits; data words in flight
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "filmic_tone_curve_rgb_core_defines.svh"
module filmic_tone_curve_rgb_core #(
  parameter int OUT_FRAC_BITS = ftc_pkg::OUT_FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ftc_in_if.sink    in_ch,
  ftc_out_if.source out_ch
);
  localparam int LAT = ftc_pkg::LANE_LAT;

  logic                   adv;
  logic [LAT-1:0]         vld_r, vld_nxt;
  logic                   ovld_r, ovld_nxt;
  logic [OUT_FRAC_BITS:0] r_c, g_c, b_c;

  assign adv         = !ovld_r || out_ch.ready;
  assign in_ch.ready = adv;

  ftc_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_red (
    .clk(clk), .en(adv), .chan_in(in_ch.red_in), .chan_out(r_c));
  ftc_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_green (
    .clk(clk), .en(adv), .chan_in(in_ch.green_in), .chan_out(g_c));
  ftc_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_blue (
    .clk(clk), .en(adv), .chan_in(in_ch.blue_in), .chan_out(b_c));

  always_comb begin
    vld_nxt  = vld_r;
    ovld_nxt = ovld_r;
    if (adv) begin
      vld_nxt  = {vld_r[LAT-2:0], in_ch.valid};
      ovld_nxt = vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.red_out   <= r_c;
      out_ch.green_out <= g_c;
      out_ch.blue_out  <= b_c;
    end
  end

  assign out_ch.valid = ovld_r;

  `FTC_ASSERT_NEXT(a_rst_clear, clk, !rst_n, !ovld_r && vld_r == '0, "valid left after reset")
  `FTC_ASSERT_SAME(a_ready, clk, rst_n, ovld_r && !out_ch.ready, !in_ch.ready, "ready while stalled")
  `FTC_ASSERT_NEXT(a_enter, clk, rst_n && in_ch.valid && in_ch.ready, !rst_n || vld_r[0], "word lost at entry")
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Filmic tone curve core: directed table then random pixels, each result
// word checked channel by channel against a fixed point curve predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  localparam int OW = ftc_pkg::OUT_FRAC_BITS + 1;
  localparam int IW = ftc_pkg::IN_W;
  localparam int N_RANDOM = 1300;

  typedef struct packed {
    logic [OW-1:0] r;
    logic [OW-1:0] g;
    logic [OW-1:0] b;
  } pixel_out_t;

  typedef struct {
    logic [IW-1:0] r;
    logic [IW-1:0] g;
    logic [IW-1:0] b;
    bit            fixed;
    logic [OW-1:0] er;
    logic [OW-1:0] eg;
    logic [OW-1:0] eb;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   send_idle = 12;
  int   recv_idle = 52;
  bit   stim_done = 1'b0;

  pixel_out_t tone_queue[$];

  ftc_in_if  in_ch();
  ftc_out_if out_ch();

  filmic_tone_curve_rgb_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [OW-1:0] tone_map(logic [IW-1:0] raw);
    logic [63:0] x, ax, t, u, num, den, ratio, curve, res, top;
    int sh;
    x = {39'd0, raw, 1'b0};
    ax = 64'd9830 * x;
    t = ax + (64'd3277 << 16);
    u = ax + (64'd32768 << 16);
    num = (t >> 8) * x + (64'd262 << 24);
    den = (u >> 8) * x + (64'd3932 << 24);
    for (int s = 0; s < 40 && den >= (64'd1 << 32); s++) begin
      num = num >> 1;
      den = den >> 1;
    end
    if (den == 0) den = 1;
    ratio = (num << 28) / den;
    curve = (ratio > 64'd17895697) ? ratio - 64'd17895697 : 64'd0;
    sh = 44 - ftc_pkg::OUT_FRAC_BITS;
    res = (curve * 64'd90378 + (64'd1 << (sh - 1))) >> sh;
    top = (64'd1 << OW) - 1;
    if (res > top) res = top;
    return res[OW-1:0];
  endfunction

  task automatic send_pixel(logic [IW-1:0] r, g, b, bit fixed,
                            logic [OW-1:0] er, eg, eb);
    pixel_out_t p;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red_in <= r;
    in_ch.green_in <= g;
    in_ch.blue_in <= b;
    if (fixed) p = '{er, eg, eb};
    else p = '{tone_map(r), tone_map(g), tone_map(b)};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tone_queue.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [IW-1:0] rand_chan();
    case ($urandom_range(3))
      0: return IW'($urandom_range(255));
      1: return IW'($urandom_range(65535));
      default: return IW'($urandom);
    endcase
  endfunction

  // receiver: ready changes at the falling edge, word checked at the rising edge
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    pixel_out_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tone_queue.size() == 0) begin
        $error("unexpected word");
        errors++;
      end else begin
        e = tone_queue.pop_front();
        if (out_ch.red_out !== e.r) begin
          $error("red_out expected %0d actual %0d", e.r, out_ch.red_out); errors++;
        end
        if (out_ch.green_out !== e.g) begin
          $error("green_out expected %0d actual %0d", e.g, out_ch.green_out); errors++;
        end
        if (out_ch.blue_out !== e.b) begin
          $error("blue_out expected %0d actual %0d", e.b, out_ch.blue_out); errors++;
        end
      end
    end
  end

  initial begin
    table_row_t rows[$];
    in_ch.valid = 1'b0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    // zero input clamps to zero curve
    rows.push_back('{24'd0, 24'd0, 24'd0, 1'b1, 15'd0, 15'd0, 15'd0});
    rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0, '0});
    rows.push_back('{24'd1, 24'd2, 24'd3, 1'b0, '0, '0, '0});
    rows.push_back('{24'h010000, 24'h050000, 24'h0B3333, 1'b0, '0, '0, '0});
    rows.push_back('{24'h555555, 24'hAAAAAA, 24'h800000, 1'b0, '0, '0, '0});
    rows.push_back('{24'h000100, 24'h008000, 24'h00FFFF, 1'b0, '0, '0, '0});
    rows.push_back('{24'hFFFFFF, 24'd0, 24'h7FFFFF, 1'b0, '0, '0, '0});
    rows.push_back('{24'h000010, 24'h000040, 24'h0000FF, 1'b0, '0, '0, '0});
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i])
      send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].fixed,
                 rows[i].er, rows[i].eg, rows[i].eb);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle = 52; recv_idle = 12;
      end
      if (n == 2 * N_RANDOM / 3) begin
        send_idle = 0; recv_idle = 0;
      end
      send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0, '0, '0);
    end
    in_ch.valid <= 1'b0;
    while (tone_queue.size() != 0) @(posedge clk);
    repeat (ftc_pkg::LANE_LAT + 10) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
